FILE: rtl/quaternion_slerp_top_macros.svh
// Assertion helpers for the file that checks itself.
`ifndef QUATERNION_SLERP_TOP_MACROS_SVH
`define QUATERNION_SLERP_TOP_MACROS_SVH

// Same-cycle implication.
`define QS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define QS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/qslerp_pkg.sv
package qslerp_pkg;

   localparam int LANES = 2;
   localparam int ISQRT_STEPS = 31;
   localparam int DIV_STEPS = 33;

   localparam logic [31:0] ONE_Q30 = 32'd1073741824;
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [32:0] WEIGHT_MAX = 33'd4294967296;
   localparam logic [15:0] BLEND_ONE = 16'd32768;

   localparam logic [31:0] ATAN_HEAD [11] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
      32'd1048576
   };

   // atan(2^-i) in Q.30; exact powers of two past the table
   function automatic logic [31:0] atan_step(input int i);
      logic [31:0] val;
      if (i <= 10) begin
         val = ATAN_HEAD[i];
      end else if (i <= 30) begin
         val = 32'd1 << (30 - i);
      end else begin
         val = '0;
      end
      return val;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] arg);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      n = arg;
      r = '0;
      b = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Inverse CORDIC gain in Q.30, worked out at elaboration
   function automatic logic [33:0] cordic_gain(input int iterations);
      logic [63:0] g2;
      logic [63:0] g;
      logic [63:0] rem;
      logic [63:0] quo;
      g2 = 64'd1 << 30;
      for (int i = 0; i < iterations; i++) begin
         if (2 * i < 62) begin
            g2 = g2 + (g2 >> (2 * i));
         end
      end
      g = isqrt64(g2 << 30);
      if (g == '0) begin
         return 34'(ONE_Q30);
      end
      rem = '0;
      quo = '0;
      for (int b = 60; b >= 0; b--) begin
         rem = (rem << 1) | ((b == 60) ? 64'd1 : 64'd0);
         if (rem >= g) begin
            rem = rem - g;
            quo = quo | (64'd1 << b);
         end
      end
      return quo[33:0];
   endfunction

endpackage

FILE: rtl/qslerp_isqrt.sv
module qslerp_isqrt #(
   parameter int SIDE_WIDTH = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [60:0]           in_radicand,
   input  logic [SIDE_WIDTH-1:0] in_side,
   output logic                  out_valid,
   output logic [30:0]           out_root,
   output logic [SIDE_WIDTH-1:0] out_side
);

   localparam int STEPS = qslerp_pkg::ISQRT_STEPS;

   logic [60:0]           num_src [STEPS];
   logic [60:0]           root_src [STEPS];
   logic                  valid_src [STEPS];
   logic [SIDE_WIDTH-1:0] side_src [STEPS];
   logic [60:0]           num_in [STEPS];
   logic [60:0]           root_in [STEPS];
   logic [60:0]           num_ff [STEPS];
   logic [60:0]           root_ff [STEPS];
   logic                  valid_ff [STEPS];
   logic [SIDE_WIDTH-1:0] side_ff [STEPS];

   always_comb begin
      num_src[0] = in_radicand;
      root_src[0] = '0;
      valid_src[0] = in_valid;
      side_src[0] = in_side;
      for (int j = 1; j < STEPS; j++) begin
         num_src[j] = num_ff[j-1];
         root_src[j] = root_ff[j-1];
         valid_src[j] = valid_ff[j-1];
         side_src[j] = side_ff[j-1];
      end
   end

   // one result bit per stage, trial bit walking down by two
   always_comb begin
      logic [60:0] bit_val;
      logic [60:0] trial;
      for (int j = 0; j < STEPS; j++) begin
         bit_val = 61'd1 << (60 - 2 * j);
         trial = root_src[j] + bit_val;
         if (num_src[j] >= trial) begin
            num_in[j] = num_src[j] - trial;
            root_in[j] = (root_src[j] >> 1) + bit_val;
         end else begin
            num_in[j] = num_src[j];
            root_in[j] = root_src[j] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < STEPS; j++) valid_ff[j] <= 1'b0;
      end else if (advance) begin
         for (int j = 0; j < STEPS; j++) valid_ff[j] <= valid_src[j];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < STEPS; j++) begin
            num_ff[j] <= num_in[j];
            root_ff[j] <= root_in[j];
            side_ff[j] <= side_src[j];
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root = root_ff[STEPS-1][30:0];
   assign out_side = side_ff[STEPS-1];

endmodule

FILE: rtl/qslerp_vector.sv
module qslerp_vector #(
   parameter int ITERATIONS = 16,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic signed [31:0]    in_dot,
   input  logic [30:0]           in_sine,
   input  logic [SIDE_WIDTH-1:0] in_side,
   output logic                  out_valid,
   output logic [31:0]           out_angle,
   output logic [SIDE_WIDTH-1:0] out_side
);

   logic signed [33:0]    x_src [ITERATIONS];
   logic signed [33:0]    y_src [ITERATIONS];
   logic signed [33:0]    z_src [ITERATIONS];
   logic                  valid_src [ITERATIONS];
   logic [SIDE_WIDTH-1:0] side_src [ITERATIONS];
   logic signed [33:0]    x_in [ITERATIONS];
   logic signed [33:0]    y_in [ITERATIONS];
   logic signed [33:0]    z_in [ITERATIONS];
   logic signed [33:0]    x_ff [ITERATIONS];
   logic signed [33:0]    y_ff [ITERATIONS];
   logic signed [33:0]    z_ff [ITERATIONS];
   logic                  valid_ff [ITERATIONS];
   logic [SIDE_WIDTH-1:0] side_ff [ITERATIONS];
   logic [31:0]           angle_in;
   logic [31:0]           angle_ff;
   logic                  out_valid_ff;
   logic [SIDE_WIDTH-1:0] out_side_ff;

   // left half plane: start rotated by a quarter turn
   always_comb begin
      if (in_dot[31]) begin
         x_src[0] = 34'(in_sine);
         y_src[0] = -34'(in_dot);
         z_src[0] = 34'(qslerp_pkg::HALF_PI_Q30);
      end else begin
         x_src[0] = 34'(in_dot);
         y_src[0] = 34'(in_sine);
         z_src[0] = '0;
      end
      valid_src[0] = in_valid;
      side_src[0] = in_side;
      for (int i = 1; i < ITERATIONS; i++) begin
         x_src[i] = x_ff[i-1];
         y_src[i] = y_ff[i-1];
         z_src[i] = z_ff[i-1];
         valid_src[i] = valid_ff[i-1];
         side_src[i] = side_ff[i-1];
      end
   end

   always_comb begin
      for (int i = 0; i < ITERATIONS; i++) begin
         if (y_src[i] > 34'sd0) begin
            x_in[i] = x_src[i] + (y_src[i] >>> i);
            y_in[i] = y_src[i] - (x_src[i] >>> i);
            z_in[i] = z_src[i] + 34'(qslerp_pkg::atan_step(i));
         end else begin
            x_in[i] = x_src[i] - (y_src[i] >>> i);
            y_in[i] = y_src[i] + (x_src[i] >>> i);
            z_in[i] = z_src[i] - 34'(qslerp_pkg::atan_step(i));
         end
      end
   end

   always_comb begin
      if (z_ff[ITERATIONS-1][33]) begin
         angle_in = '0;
      end else if (z_ff[ITERATIONS-1] > signed'(34'(qslerp_pkg::PI_Q30))) begin
         angle_in = qslerp_pkg::PI_Q30;
      end else begin
         angle_in = z_ff[ITERATIONS-1][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ITERATIONS; i++) valid_ff[i] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i < ITERATIONS; i++) valid_ff[i] <= valid_src[i];
         out_valid_ff <= valid_ff[ITERATIONS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < ITERATIONS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
            side_ff[i] <= side_src[i];
         end
         angle_ff <= angle_in;
         out_side_ff <= side_ff[ITERATIONS-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_angle = angle_ff;
   assign out_side = out_side_ff;

endmodule

FILE: rtl/qslerp_rotate.sv
module qslerp_rotate #(
   parameter int ITERATIONS = 16,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [31:0]           in_angle [qslerp_pkg::LANES],
   input  logic [SIDE_WIDTH-1:0] in_side,
   output logic                  out_valid,
   output logic signed [33:0]    out_sine [qslerp_pkg::LANES],
   output logic [SIDE_WIDTH-1:0] out_side
);

   localparam int LANES = qslerp_pkg::LANES;
   localparam logic signed [33:0] GAIN = signed'(qslerp_pkg::cordic_gain(ITERATIONS));

   logic signed [33:0]    fold_in [LANES];
   logic signed [33:0]    fold_ff [LANES];
   logic                  fold_valid_ff;
   logic [SIDE_WIDTH-1:0] fold_side_ff;
   logic signed [33:0]    x_src [ITERATIONS][LANES];
   logic signed [33:0]    y_src [ITERATIONS][LANES];
   logic signed [33:0]    z_src [ITERATIONS][LANES];
   logic                  valid_src [ITERATIONS];
   logic [SIDE_WIDTH-1:0] side_src [ITERATIONS];
   logic signed [33:0]    x_in [ITERATIONS][LANES];
   logic signed [33:0]    y_in [ITERATIONS][LANES];
   logic signed [33:0]    z_in [ITERATIONS][LANES];
   logic signed [33:0]    x_ff [ITERATIONS][LANES];
   logic signed [33:0]    y_ff [ITERATIONS][LANES];
   logic signed [33:0]    z_ff [ITERATIONS][LANES];
   logic                  valid_ff [ITERATIONS];
   logic [SIDE_WIDTH-1:0] side_ff [ITERATIONS];

   // fold the second quadrant onto the first
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (in_angle[l] > qslerp_pkg::HALF_PI_Q30) begin
            fold_in[l] = 34'(qslerp_pkg::PI_Q30 - in_angle[l]);
         end else begin
            fold_in[l] = 34'(in_angle[l]);
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         x_src[0][l] = GAIN;
         y_src[0][l] = '0;
         z_src[0][l] = fold_ff[l];
      end
      valid_src[0] = fold_valid_ff;
      side_src[0] = fold_side_ff;
      for (int i = 1; i < ITERATIONS; i++) begin
         for (int l = 0; l < LANES; l++) begin
            x_src[i][l] = x_ff[i-1][l];
            y_src[i][l] = y_ff[i-1][l];
            z_src[i][l] = z_ff[i-1][l];
         end
         valid_src[i] = valid_ff[i-1];
         side_src[i] = side_ff[i-1];
      end
   end

   always_comb begin
      for (int i = 0; i < ITERATIONS; i++) begin
         for (int l = 0; l < LANES; l++) begin
            if (!z_src[i][l][33]) begin
               x_in[i][l] = x_src[i][l] - (y_src[i][l] >>> i);
               y_in[i][l] = y_src[i][l] + (x_src[i][l] >>> i);
               z_in[i][l] = z_src[i][l] - 34'(qslerp_pkg::atan_step(i));
            end else begin
               x_in[i][l] = x_src[i][l] + (y_src[i][l] >>> i);
               y_in[i][l] = y_src[i][l] - (x_src[i][l] >>> i);
               z_in[i][l] = z_src[i][l] + 34'(qslerp_pkg::atan_step(i));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
         for (int i = 0; i < ITERATIONS; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         fold_valid_ff <= in_valid;
         for (int i = 0; i < ITERATIONS; i++) valid_ff[i] <= valid_src[i];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fold_ff <= fold_in;
         fold_side_ff <= in_side;
         for (int i = 0; i < ITERATIONS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
            side_ff[i] <= side_src[i];
         end
      end
   end

   assign out_valid = valid_ff[ITERATIONS-1];
   assign out_sine = y_ff[ITERATIONS-1];
   assign out_side = side_ff[ITERATIONS-1];

endmodule

FILE: rtl/qslerp_divide.sv
module qslerp_divide #(
   parameter int SIDE_WIDTH = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic signed [33:0]    in_num [qslerp_pkg::LANES],
   input  logic [30:0]           in_den,
   input  logic [SIDE_WIDTH-1:0] in_side,
   output logic                  out_valid,
   output logic signed [33:0]    out_weight [qslerp_pkg::LANES],
   output logic [SIDE_WIDTH-1:0] out_side
);

   localparam int LANES = qslerp_pkg::LANES;
   localparam int STEPS = qslerp_pkg::DIV_STEPS;

   // stage 0 prepares magnitudes, stages 1..STEPS each settle one quotient bit
   logic [63:0]           rem_in [STEPS+1][LANES];
   logic [32:0]           quo_in [STEPS+1][LANES];
   logic                  neg_in [LANES];
   logic                  ovf_in [LANES];
   logic [63:0]           rem_ff [STEPS+1][LANES];
   logic [32:0]           quo_ff [STEPS+1][LANES];
   logic                  neg_ff [STEPS+1][LANES];
   logic                  ovf_ff [STEPS+1][LANES];
   logic [30:0]           den_ff [STEPS+1];
   logic                  valid_ff [STEPS+1];
   logic [SIDE_WIDTH-1:0] side_ff [STEPS+1];
   logic signed [33:0]    weight_in [LANES];
   logic signed [33:0]    weight_ff [LANES];
   logic                  out_valid_ff;
   logic [SIDE_WIDTH-1:0] out_side_ff;

   always_comb begin
      logic [34:0] mag;
      logic [63:0] trial;
      for (int l = 0; l < LANES; l++) begin
         neg_in[l] = in_num[l][33];
         mag = neg_in[l] ? 35'(-35'(in_num[l])) : 35'(in_num[l]);
         // quotient would reach 2^33 or more: it saturates anyway
         ovf_in[l] = mag >= (35'(in_den) << 3);
         rem_in[0][l] = 64'(mag) << 30;
         quo_in[0][l] = '0;
      end
      for (int s = 1; s <= STEPS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            trial = 64'(den_ff[s-1]) << (STEPS - s);
            if (rem_ff[s-1][l] >= trial) begin
               rem_in[s][l] = rem_ff[s-1][l] - trial;
               quo_in[s][l] = quo_ff[s-1][l] | (33'd1 << (STEPS - s));
            end else begin
               rem_in[s][l] = rem_ff[s-1][l];
               quo_in[s][l] = quo_ff[s-1][l];
            end
         end
      end
   end

   always_comb begin
      logic [32:0] q;
      for (int l = 0; l < LANES; l++) begin
         if (ovf_ff[STEPS][l] || quo_ff[STEPS][l] > qslerp_pkg::WEIGHT_MAX) begin
            q = qslerp_pkg::WEIGHT_MAX;
         end else begin
            q = quo_ff[STEPS][l];
         end
         weight_in[l] = neg_ff[STEPS][l] ? -signed'(34'(q)) : signed'(34'(q));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS; s++) valid_ff[s] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= STEPS; s++) valid_ff[s] <= valid_ff[s-1];
         out_valid_ff <= valid_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff[0] <= in_den;
         side_ff[0] <= in_side;
         for (int l = 0; l < LANES; l++) begin
            neg_ff[0][l] <= neg_in[l];
            ovf_ff[0][l] <= ovf_in[l];
         end
         for (int s = 1; s <= STEPS; s++) begin
            den_ff[s] <= den_ff[s-1];
            side_ff[s] <= side_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            ovf_ff[s] <= ovf_ff[s-1];
         end
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         weight_ff <= weight_in;
         out_side_ff <= side_ff[STEPS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_weight = weight_ff;
   assign out_side = out_side_ff;

endmodule

FILE: rtl/quaternion_slerp_top.sv
// Quaternion slerp, fully pipelined: one transaction accepted per cycle unless skid is full.
// From acceptance to rsp_tvalid a transaction runs through the 31-step square root,
// the two CORDIC chains and the 33-step divider.
// An output register plus one skid entry keep intake running while one result waits.
// Synchronous active-high reset clears every valid bit; payload is not reset.
`include "quaternion_slerp_top_macros.svh"

module quaternion_slerp_top #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // q_x, q_y, q_z, q_w, r_x, r_y, r_z, r_w, blend
   input  logic [8*COMPONENT_WIDTH+15:0]  req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_x, out_y, out_z, out_w
   output logic [4*COMPONENT_WIDTH-1:0]   rsp_tdata,
   // degenerate
   output logic [0:0]                     rsp_tuser
);

   localparam int W = COMPONENT_WIDTH;
   localparam int QR_W = 8 * W;
   localparam int Q30_SHIFT = (W <= 31) ? 31 - W : 0;
   localparam int ROUND_SHIFT = (W < 31) ? 31 - W : 1;
   localparam logic signed [36:0] SAT_HI = (37'sd1 <<< (W - 1)) - 37'sd1;
   localparam logic signed [36:0] SAT_LO = -SAT_HI - 37'sd1;
   localparam int SQ_SIDE_W = QR_W + 16 + 1 + 32;
   localparam int VEC_SIDE_W = QR_W + 16 + 1 + 31;
   localparam int ROT_SIDE_W = QR_W + 1 + 31;
   localparam int DIV_SIDE_W = QR_W + 1;
   localparam int LANES = qslerp_pkg::LANES;

   function automatic logic signed [31:0] to_q30(input logic [W-1:0] raw);
      logic signed [32:0] ext;
      ext = 33'(signed'(raw));
      if (W <= 31) begin
         return 32'(ext <<< Q30_SHIFT);
      end
      return 32'(ext >>> 1);
   endfunction

   function automatic logic [W-1:0] from_q30(input logic signed [34:0] v);
      logic signed [36:0] ext;
      logic signed [36:0] r;
      ext = 37'(v);
      if (W < 31) begin
         r = (ext + (37'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      end else if (W == 31) begin
         r = ext;
      end else begin
         r = ext <<< 1;
      end
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[W-1:0];
   endfunction

   logic advance;

   // dot product stages
   logic signed [33:0] s1_prod_in [4];
   logic signed [33:0] s1_prod_ff [4];
   logic [QR_W-1:0]    s1_qr_ff;
   logic [15:0]        s1_blend_in;
   logic [15:0]        s1_blend_ff;
   logic               s1_valid_ff;
   logic signed [31:0] s2_d_in;
   logic signed [31:0] s2_d_ff;
   logic [QR_W-1:0]    s2_qr_ff;
   logic [15:0]        s2_blend_ff;
   logic               s2_valid_ff;
   logic [30:0]        s3_ss_in;
   logic [30:0]        s3_ss_ff;
   logic signed [31:0] s3_d_ff;
   logic [QR_W-1:0]    s3_qr_ff;
   logic [15:0]        s3_blend_ff;
   logic               s3_degen_ff;
   logic               s3_valid_ff;

   logic                  sq_valid;
   logic [30:0]           sq_root;
   logic [SQ_SIDE_W-1:0]  sq_side;
   logic                  vec_valid;
   logic [31:0]           vec_angle;
   logic [VEC_SIDE_W-1:0] vec_side;

   logic [31:0]           pt_angle_in [LANES];
   logic [31:0]           pt_angle_ff [LANES];
   logic [ROT_SIDE_W-1:0] pt_side_ff;
   logic                  pt_valid_ff;

   logic                  rot_valid;
   logic signed [33:0]    rot_sine [LANES];
   logic [ROT_SIDE_W-1:0] rot_side;
   logic                  div_valid;
   logic signed [33:0]    div_weight [LANES];
   logic [DIV_SIDE_W-1:0] div_side;

   logic signed [33:0] f1_q_in [4];
   logic signed [33:0] f1_r_in [4];
   logic signed [33:0] f1_q_ff [4];
   logic signed [33:0] f1_r_ff [4];
   logic [4*W-1:0]     f1_qraw_ff;
   logic               f1_degen_ff;
   logic               f1_valid_ff;
   logic [4*W-1:0]     f2_data;

   logic [4*W-1:0] rsp_data_ff;
   logic           rsp_user_ff;
   logic           rsp_valid_ff;
   logic [4*W-1:0] skid_data_ff;
   logic           skid_user_ff;
   logic           skid_valid_ff;
   logic           rsp_take;
   logic           pipe_push;

   assign advance = !skid_valid_ff;
   assign req_tready = advance;

   always_comb begin
      logic signed [63:0] prod;
      for (int k = 0; k < 4; k++) begin
         prod = to_q30(req_tdata[k*W +: W]) * to_q30(req_tdata[(4+k)*W +: W]);
         s1_prod_in[k] = prod[63:30];
      end
      if (req_tdata[8*W +: 16] > qslerp_pkg::BLEND_ONE) begin
         s1_blend_in = qslerp_pkg::BLEND_ONE;
      end else begin
         s1_blend_in = req_tdata[8*W +: 16];
      end
   end

   // clamp the dot product to plus or minus one
   always_comb begin
      logic signed [35:0] sum;
      sum = 36'(s1_prod_ff[0]) + 36'(s1_prod_ff[1]) + 36'(s1_prod_ff[2])
          + 36'(s1_prod_ff[3]);
      if (sum > signed'(36'(qslerp_pkg::ONE_Q30))) begin
         s2_d_in = signed'(qslerp_pkg::ONE_Q30);
      end else if (sum < -signed'(36'(qslerp_pkg::ONE_Q30))) begin
         s2_d_in = -signed'(qslerp_pkg::ONE_Q30);
      end else begin
         s2_d_in = 32'(sum);
      end
   end

   always_comb begin
      logic signed [63:0] dd;
      dd = s2_d_ff * s2_d_ff;
      s3_ss_in = 31'(qslerp_pkg::ONE_Q30) - dd[60:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         pt_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         pt_valid_ff <= vec_valid;
         f1_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff <= s1_prod_in;
         s1_qr_ff <= req_tdata[QR_W-1:0];
         s1_blend_ff <= s1_blend_in;
         s2_d_ff <= s2_d_in;
         s2_qr_ff <= s1_qr_ff;
         s2_blend_ff <= s1_blend_ff;
         s3_ss_ff <= s3_ss_in;
         s3_degen_ff <= (s3_ss_in == '0);
         s3_d_ff <= s2_d_ff;
         s3_qr_ff <= s2_qr_ff;
         s3_blend_ff <= s2_blend_ff;
      end
   end

   qslerp_isqrt #(
      .SIDE_WIDTH(SQ_SIDE_W)
   ) u_isqrt (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (s3_valid_ff),
      .in_radicand({s3_ss_ff, 30'd0}),
      .in_side    ({s3_d_ff, s3_degen_ff, s3_blend_ff, s3_qr_ff}),
      .out_valid  (sq_valid),
      .out_root   (sq_root),
      .out_side   (sq_side)
   );

   qslerp_vector #(
      .ITERATIONS(TRIG_ITERATIONS),
      .SIDE_WIDTH(VEC_SIDE_W)
   ) u_vector (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (sq_valid),
      .in_dot   (signed'(sq_side[QR_W+17 +: 32])),
      .in_sine  (sq_root),
      .in_side  ({sq_root, sq_side[QR_W+16], sq_side[QR_W +: 16], sq_side[QR_W-1:0]}),
      .out_valid(vec_valid),
      .out_angle(vec_angle),
      .out_side (vec_side)
   );

   // ph*t and ph - ph*t
   always_comb begin
      logic [47:0] prod;
      prod = vec_angle * vec_side[QR_W +: 16];
      pt_angle_in[1] = prod[46:15];
      pt_angle_in[0] = vec_angle - prod[46:15];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pt_angle_ff <= pt_angle_in;
         pt_side_ff <= {vec_side[QR_W+17 +: 31], vec_side[QR_W+16], vec_side[QR_W-1:0]};
      end
   end

   qslerp_rotate #(
      .ITERATIONS(TRIG_ITERATIONS),
      .SIDE_WIDTH(ROT_SIDE_W)
   ) u_rotate (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (pt_valid_ff),
      .in_angle (pt_angle_ff),
      .in_side  (pt_side_ff),
      .out_valid(rot_valid),
      .out_sine (rot_sine),
      .out_side (rot_side)
   );

   qslerp_divide #(
      .SIDE_WIDTH(DIV_SIDE_W)
   ) u_divide (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (rot_valid),
      .in_num    (rot_sine),
      .in_den    (rot_side[QR_W+1 +: 31]),
      .in_side   (rot_side[QR_W:0]),
      .out_valid (div_valid),
      .out_weight(div_weight),
      .out_side  (div_side)
   );

   always_comb begin
      logic signed [65:0] qp;
      logic signed [65:0] rp;
      for (int k = 0; k < 4; k++) begin
         qp = to_q30(div_side[k*W +: W]) * div_weight[0];
         rp = to_q30(div_side[(4+k)*W +: W]) * div_weight[1];
         f1_q_in[k] = qp[63:30];
         f1_r_in[k] = rp[63:30];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_q_ff <= f1_q_in;
         f1_r_ff <= f1_r_in;
         f1_qraw_ff <= div_side[4*W-1:0];
         f1_degen_ff <= div_side[QR_W];
      end
   end

   // degenerate: hand q back untouched
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (f1_degen_ff) begin
            f2_data[k*W +: W] = f1_qraw_ff[k*W +: W];
         end else begin
            f2_data[k*W +: W] = from_q30(35'(f1_q_ff[k]) + 35'(f1_r_ff[k]));
         end
      end
   end

   assign rsp_take = rsp_valid_ff && rsp_tready;
   assign pipe_push = advance && f1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (pipe_push) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_ff <= skid_data_ff;
            rsp_user_ff <= skid_user_ff;
         end
      end else if (pipe_push) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_data_ff <= f2_data;
            rsp_user_ff <= f1_degen_ff;
         end else begin
            skid_data_ff <= f2_data;
            skid_user_ff <= f1_degen_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   `QS_ASSERT_NOW(a_skid_behind_output, clock, reset, skid_valid_ff, rsp_valid_ff,
      "skid entry held without a pending output")
   `QS_ASSERT_NEXT(a_stalled_push_to_skid, clock, reset,
      pipe_push && rsp_valid_ff && !rsp_tready, skid_valid_ff,
      "result pushed during output stall was not parked")
   `QS_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && rsp_tready,
      rsp_valid_ff && !skid_valid_ff, "skid entry did not move to output")

endmodule
